FILE: rtl/fsup_pkg.sv
// ----------------------------------------------------------------------------
// fsup_pkg
// Types and constants shared by the sector update planner modules.
// ----------------------------------------------------------------------------
package fsup_pkg;

  localparam int ADDR_W = 24;
  localparam int MASK_W = 16;
  localparam int JOB_DEPTH = 2;

  localparam int SECTOR_BYTES_DEF = 4096;
  localparam int PAGE_BYTES_DEF = 256;
  localparam logic [ADDR_W-1:0] REGION_BASE_RESET = 24'h200000;

  localparam logic [1:0] ACT_SKIP = 2'd0;
  localparam logic [1:0] ACT_ERASE = 2'd1;
  localparam logic [1:0] ACT_PROGRAM = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] byte_offset;
    logic [7:0] old_byte;
    logic [7:0] new_byte;
    logic chunk_end;
  } in_t;

  typedef struct packed {
    logic [1:0] action;
    logic [ADDR_W-1:0] flash_address;
    logic last;
  } out_t;

  // one finished chunk, handed from front to back
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic erase;
    logic [ADDR_W-1:0] sector;
  } job_t;

endpackage

FILE: rtl/fsup_front.sv
// ----------------------------------------------------------------------------
// fsup_front
// Accepts bytes, forms the flash address and accumulates page/erase marks;
// pushes a job on the chunk-end byte.
// ----------------------------------------------------------------------------
module fsup_front #(
  parameter int SECTOR_BYTES = fsup_pkg::SECTOR_BYTES_DEF,
  parameter int PAGE_BYTES = fsup_pkg::PAGE_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  fsup_pkg::in_t in_data,
  input  logic cfg_write,
  input  logic [fsup_pkg::ADDR_W-1:0] cfg_data,
  input  logic q_full,
  output logic push,
  output fsup_pkg::job_t push_job
);
  import fsup_pkg::*;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam logic [ADDR_W-1:0] SECTOR_MASK = ADDR_W'(SECTOR_BYTES - 1);

  logic [ADDR_W-1:0] region_base;
  logic [MASK_W-1:0] changed_mask, changed_mask_next;
  logic erase_flag, erase_flag_next;

  logic accept;
  logic [ADDR_W-1:0] addr, sec_off, page_full;
  logic [3:0] page;
  logic changed;

  assign in_stall = q_full;
  assign accept = in_valid && !q_full;

  always_comb begin
    addr = region_base + in_data.byte_offset;
    sec_off = addr & SECTOR_MASK;
    page_full = sec_off >> PAGE_SHIFT;
    page = page_full[3:0];
    changed = in_data.old_byte != in_data.new_byte;
    changed_mask_next = changed_mask;
    erase_flag_next = erase_flag;
    if (changed) begin
      changed_mask_next = changed_mask | (MASK_W'(1) << page);
      if ((in_data.new_byte & ~in_data.old_byte) != 8'd0) erase_flag_next = 1'b1;
    end
  end

  assign push = accept && in_data.chunk_end;
  assign push_job = '{mask: changed_mask_next, erase: erase_flag_next,
                      sector: addr & ~SECTOR_MASK};

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= REGION_BASE_RESET;
      changed_mask <= '0;
      erase_flag <= 1'b0;
    end else begin
      if (cfg_write) region_base <= cfg_data;
      if (accept) begin
        if (in_data.chunk_end) begin
          changed_mask <= '0;
          erase_flag <= 1'b0;
        end else begin
          changed_mask <= changed_mask_next;
          erase_flag <= erase_flag_next;
        end
      end
    end
  end

endmodule

FILE: rtl/fsup_queue.sv
// ----------------------------------------------------------------------------
// fsup_queue
// Short job FIFO between the front and the command sequencer.
// ----------------------------------------------------------------------------
module fsup_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  fsup_pkg::job_t push_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output fsup_pkg::job_t pop_job
);
  import fsup_pkg::*;

  localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOB_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(JOB_DEPTH - 1);

  job_t mem [JOB_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = count == CNT_W'(JOB_DEPTH);
  assign not_empty = count != '0;
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

FILE: rtl/fsup_back.sv
// ----------------------------------------------------------------------------
// fsup_back
// Command sequencer: turns one job into skip, or page programs after an optional erase,
// one command per cycle into a registered output while the output is not stalled.
// ----------------------------------------------------------------------------
module fsup_back #(
  parameter int SECTOR_BYTES = fsup_pkg::SECTOR_BYTES_DEF,
  parameter int PAGE_BYTES = fsup_pkg::PAGE_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_not_empty,
  input  fsup_pkg::job_t q_job,
  output logic q_pop,
  output logic out_valid,
  input  logic out_stall,
  output fsup_pkg::out_t out_data
);
  import fsup_pkg::*;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  // pages handled per sector: clamp to the mask width, at least one
  localparam int PAGES_RAW = SECTOR_BYTES / PAGE_BYTES;
  localparam int NPAGES = (PAGES_RAW > MASK_W) ? MASK_W : ((PAGES_RAW == 0) ? 1 : PAGES_RAW);
  localparam logic [MASK_W-1:0] ALL_PAGES = MASK_W'((33'd1 << NPAGES) - 33'd1);

  logic busy, skip, erase_pend;
  logic [MASK_W-1:0] mask, rest;
  logic [ADDR_W-1:0] sector;
  logic [3:0] low_page;
  logic emit;

  // lowest marked page
  always_comb begin
    low_page = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (mask[i]) low_page = 4'(i);
    end
    rest = mask & ~(MASK_W'(1) << low_page);
  end

  assign emit = busy && (!out_valid || !out_stall);
  assign q_pop = !busy && q_not_empty;

  always_ff @(posedge clk) begin
    if (emit) begin
      if (skip) begin
        out_data <= '{action: ACT_SKIP, flash_address: sector, last: 1'b1};
      end else if (erase_pend) begin
        out_data <= '{action: ACT_ERASE, flash_address: sector, last: 1'b0};
      end else begin
        out_data <= '{action: ACT_PROGRAM,
                      flash_address: sector + (ADDR_W'(low_page) << PAGE_SHIFT),
                      last: rest == '0};
      end
    end
    if (q_pop) begin
      skip <= q_job.mask == '0;
      mask <= q_job.erase ? ALL_PAGES : q_job.mask;
      sector <= q_job.sector;
    end else if (emit && !skip && !erase_pend) begin
      mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      erase_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (q_pop) begin
        busy <= 1'b1;
        erase_pend <= q_job.erase;
      end else if (emit) begin
        if (skip) busy <= 1'b0;
        else if (erase_pend) erase_pend <= 1'b0;
        else if (rest == '0) busy <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/flash_sector_update_planner_unit.sv
// ----------------------------------------------------------------------------
// flash_sector_update_planner_unit
// Plans the erase/program commands for a chunk of bytes within one sector.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle. A byte without chunk_end produces nothing;
// the chunk-end byte closes the chunk and queues a job (two-deep queue), and
// the input stalls only while that queue is full. The command sequencer then
// emits 1 to 17 commands for the chunk, one per cycle when the output is not
// stalled: a single skip, or an optional sector erase followed by one page
// program per marked page (all after an erase) in ascending order, with last
// set on the final one. SECTOR_BYTES and PAGE_BYTES must be powers of two;
// with more than 16 pages a sector the page index wraps onto 16 page marks.
module flash_sector_update_planner_unit #(
  parameter int SECTOR_BYTES = fsup_pkg::SECTOR_BYTES_DEF,
  parameter int PAGE_BYTES = fsup_pkg::PAGE_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  fsup_pkg::in_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output fsup_pkg::out_t out_data,
  input  logic cfg_write,
  input  logic [fsup_pkg::ADDR_W-1:0] cfg_data
);
  import fsup_pkg::*;

  logic push, q_full, q_pop, q_not_empty;
  job_t push_job, q_job;

  fsup_front #(.SECTOR_BYTES(SECTOR_BYTES), .PAGE_BYTES(PAGE_BYTES)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data, .cfg_write, .cfg_data,
    .q_full, .push, .push_job
  );

  fsup_queue u_queue (
    .clk, .rst, .push, .push_job, .full(q_full), .pop(q_pop),
    .not_empty(q_not_empty), .pop_job(q_job)
  );

  fsup_back #(.SECTOR_BYTES(SECTOR_BYTES), .PAGE_BYTES(PAGE_BYTES)) u_back (
    .clk, .rst, .q_not_empty, .q_job, .q_pop, .out_valid, .out_stall, .out_data
  );

endmodule
